// File: rtl/sets_pkg.sv
`timescale 1ns / 1ps

package sets_pkg;

  // Sample and register widths
  localparam int SAMPLE_W = 16;
  localparam int COL_W    = 10;
  localparam int ROW_W    = 8;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 3;
  localparam int CNT_W    = 4;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_INNER_WIDTH     = 3'd0;
  localparam logic [IDX_W-1:0] REG_INNER_HEIGHT    = 3'd1;
  localparam logic [IDX_W-1:0] REG_DECIMATION      = 3'd2;
  localparam logic [IDX_W-1:0] REG_TRIGGER_LEVEL   = 3'd3;
  localparam logic [IDX_W-1:0] REG_TRIGGER_FALLING = 3'd4;

  // Register reset values
  localparam logic [COL_W-1:0]           WIDTH_RESET  = 10'd78;
  localparam logic [ROW_W-1:0]           HEIGHT_RESET = 8'd22;
  localparam logic [SAMPLE_W-1:0]        DECIM_RESET  = 16'd1;
  localparam logic signed [SAMPLE_W-1:0] LEVEL_RESET  = 16'sd0;

  // One plotted point on its way to the row mapping stage
  typedef struct packed {
    logic [COL_W-1:0]           column;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] sample_before;
    logic                       draw_span;
    logic                       restarted;
  } plot_t;

  // Result of the remainder unit
  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] value;
  } rem_res_t;

endpackage

// File: rtl/scope_edge_trigger_sweep.sv
`timescale 1ns / 1ps

// Oscilloscope edge-trigger sweep. Takes one signed 16-bit sample per
// transaction and, once per plotted sample, gives the sweep column and the
// screen rows of the current and previous samples. A new sample is taken
// every cycle while in_stall is low; the edge that accepts a sample loads
// the decision (plot stage) register, and the row mapping then loads the
// output register once the output is not stalled. Samples that are skipped by
// decimation or arrive while waiting for a trigger give no result. A write to
// the decimation register stalls the input through the write cycle, a
// bit-serial unit recomputing the phase remainder, and the load of the new
// remainder; no other write causes a stall. The user must write configuration
// only while the block is idle; the block itself does not enforce it.
module scope_edge_trigger_sweep (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [sets_pkg::IDX_W-1:0]           cfg_index,
  input  logic [sets_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [sets_pkg::SAMPLE_W-1:0] sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [sets_pkg::COL_W-1:0]           column,
  output logic [sets_pkg::ROW_W-1:0]           row_now,
  output logic [sets_pkg::ROW_W-1:0]           row_before,
  output logic                                 draw_span,
  output logic                                 restarted
);

  logic [sets_pkg::COL_W-1:0]           inner_width;
  logic [sets_pkg::ROW_W-1:0]           inner_height;
  logic [sets_pkg::SAMPLE_W-1:0]        decimation;
  logic signed [sets_pkg::SAMPLE_W-1:0] trigger_level;
  logic                                 trigger_falling;

  logic [sets_pkg::SAMPLE_W-1:0] divisor;
  logic [sets_pkg::SAMPLE_W-1:0] phase;
  logic                          dec_write;
  logic                          rem_busy;
  sets_pkg::rem_res_t            rem_res;
  logic                          advance;
  logic                          accept;
  logic                          plot_valid;
  sets_pkg::plot_t               plot;
  logic [sets_pkg::ROW_W-1:0]    row_now_next;
  logic [sets_pkg::ROW_W-1:0]    row_before_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inner_width     <= sets_pkg::WIDTH_RESET;
      inner_height    <= sets_pkg::HEIGHT_RESET;
      decimation      <= sets_pkg::DECIM_RESET;
      trigger_level   <= sets_pkg::LEVEL_RESET;
      trigger_falling <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        sets_pkg::REG_INNER_WIDTH:     inner_width     <= cfg_data[sets_pkg::COL_W-1:0];
        sets_pkg::REG_INNER_HEIGHT:    inner_height    <= cfg_data[sets_pkg::ROW_W-1:0];
        sets_pkg::REG_DECIMATION:      decimation      <= cfg_data;
        sets_pkg::REG_TRIGGER_LEVEL:   trigger_level   <= cfg_data;
        sets_pkg::REG_TRIGGER_FALLING: trigger_falling <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Zero decimation plots every sample
  assign divisor   = (decimation == '0) ? sets_pkg::SAMPLE_W'(1) : decimation;
  assign dec_write = cfg_write && (cfg_index == sets_pkg::REG_DECIMATION);

  // Handshake; hold input until the new remainder is loaded
  assign advance  = !out_valid || !out_stall;
  assign in_stall = (plot_valid && !advance) || !advance || rem_busy || dec_write ||
                    rem_res.done;
  assign accept   = in_valid && !in_stall;

  sets_rem_unit u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (dec_write),
    .phase   (phase),
    .divisor (divisor),
    .busy    (rem_busy),
    .res     (rem_res)
  );

  sets_sweep_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .advance         (advance),
    .sample          (sample),
    .inner_width     (inner_width),
    .divisor         (divisor),
    .trigger_level   (trigger_level),
    .trigger_falling (trigger_falling),
    .rem_res         (rem_res),
    .phase           (phase),
    .plot_valid      (plot_valid),
    .plot            (plot)
  );

  sets_row_map u_row_now (
    .sample (plot.sample),
    .height (inner_height),
    .row    (row_now_next)
  );

  sets_row_map u_row_before (
    .sample (plot.sample_before),
    .height (inner_height),
    .row    (row_before_next)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= plot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && plot_valid) begin
      column     <= plot.column;
      row_now    <= row_now_next;
      row_before <= row_before_next;
      draw_span  <= plot.draw_span;
      restarted  <= plot.restarted;
    end
  end

`ifndef SYNTH
  // A restart always plots at the left edge
  a_restart_col0: assert property (@(posedge clk) disable iff (rst)
    out_valid && restarted |-> column == '0)
    else $error("restart result not at column 0");

  // Span flag follows the column
  a_span_col: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> draw_span == (column != '0))
    else $error("draw_span does not match column");

  // Rows stay on screen
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> row_now <= inner_height && row_before <= inner_height)
    else $error("row beyond inner_height");

  // Column stays inside the sweep
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> column < inner_width)
    else $error("column beyond sweep width");

  // No sample taken while the remainder is recomputed
  a_rem_hold: assert property (@(posedge clk) disable iff (rst)
    rem_busy |-> !accept && $stable(phase))
    else $error("sample accepted during remainder update");
`endif

endmodule

// File: rtl/sets_rem_unit.sv
`timescale 1ns / 1ps

// Bit-serial remainder of the phase counter by the decimation divisor.
// Runs once after each decimation write, one quotient bit per cycle.
module sets_rem_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [sets_pkg::SAMPLE_W-1:0]   phase,
  input  logic [sets_pkg::SAMPLE_W-1:0]   divisor,
  output logic                            busy,
  output sets_pkg::rem_res_t              res
);

  logic [sets_pkg::CNT_W-1:0]    cnt;
  logic [sets_pkg::SAMPLE_W-1:0] acc;
  logic [sets_pkg::SAMPLE_W:0]   trial;
  logic [sets_pkg::SAMPLE_W-1:0] acc_next;
  logic                          rem_done;
  logic [sets_pkg::SAMPLE_W-1:0] rem_value;

  // One restoring step: shift in the next phase bit, subtract if it fits
  always_comb begin
    trial = {acc, phase[cnt]};
    if (trial >= {1'b0, divisor}) begin
      acc_next = sets_pkg::SAMPLE_W'(trial - {1'b0, divisor});
    end else begin
      acc_next = trial[sets_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      rem_done <= 1'b0;
    end else begin
      rem_done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '1;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy     <= 1'b0;
          rem_done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
    end else if (busy) begin
      acc <= acc_next;
      if (cnt == '0) begin
        rem_value <= acc_next;
      end
    end
  end

  assign res = {rem_done, rem_value};

endmodule

// File: rtl/sets_row_map.sv
`timescale 1ns / 1ps

// Maps a sample onto a screen row: H - ceil((s + 32767) * H / 65535).
// Division by 65535 uses 2^16 - 1: quotient from the high bits, then a
// single correction compare.
module sets_row_map (
  input  logic signed [sets_pkg::SAMPLE_W-1:0] sample,
  input  logic [sets_pkg::ROW_W-1:0]           height,
  output logic [sets_pkg::ROW_W-1:0]           row
);

  localparam int PROD_W = sets_pkg::SAMPLE_W + sets_pkg::ROW_W;

  logic [sets_pkg::SAMPLE_W-1:0] biased;
  logic [PROD_W-1:0]             prod;
  logic [PROD_W-1:0]             rounded;
  logic [sets_pkg::ROW_W-1:0]    q_est;
  logic [sets_pkg::SAMPLE_W:0]   r_est;
  logic [sets_pkg::ROW_W-1:0]    q;

  always_comb begin
    biased  = sample + sets_pkg::SAMPLE_MAX;
    prod    = PROD_W'(biased) * PROD_W'(height);
    rounded = prod + PROD_W'(17'd65534);
    q_est   = rounded[PROD_W-1:sets_pkg::SAMPLE_W];
    r_est   = {1'b0, rounded[sets_pkg::SAMPLE_W-1:0]} + (sets_pkg::SAMPLE_W+1)'(q_est);
    q       = q_est + ((r_est >= 17'd65535) ? 8'd1 : 8'd0);
    // Lowest sample sits below the scale and lands on the bottom row
    if (sample == sets_pkg::SAMPLE_MIN) begin
      row = height;
    end else begin
      row = height - q;
    end
  end

endmodule

// File: rtl/sets_sweep_ctrl.sv
`timescale 1ns / 1ps

// Sweep state: decimation phase, its remainder, column and last sample.
// Decides per accepted transaction whether it triggers and whether it plots.
module sets_sweep_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                advance,
  input  logic signed [sets_pkg::SAMPLE_W-1:0] sample,
  input  logic [sets_pkg::COL_W-1:0]          inner_width,
  input  logic [sets_pkg::SAMPLE_W-1:0]       divisor,
  input  logic signed [sets_pkg::SAMPLE_W-1:0] trigger_level,
  input  logic                                trigger_falling,
  input  sets_pkg::rem_res_t                  rem_res,
  output logic [sets_pkg::SAMPLE_W-1:0]       phase,
  output logic                                plot_valid,
  output sets_pkg::plot_t                     plot
);

  logic [sets_pkg::SAMPLE_W-1:0]        rem;
  logic [sets_pkg::COL_W-1:0]           sweep_column;
  logic signed [sets_pkg::SAMPLE_W-1:0] last_sample;

  logic                          full;
  logic                          crossed;
  logic                          hit;
  logic                          still_full;
  logic                          do_plot;
  logic [sets_pkg::SAMPLE_W-1:0] phase_inc;
  logic [sets_pkg::SAMPLE_W:0]   rem_plus;
  logic [sets_pkg::SAMPLE_W-1:0] rem_inc;
  logic [sets_pkg::COL_W-1:0]    col_eff;
  logic [sets_pkg::SAMPLE_W-1:0] phase_next;
  logic [sets_pkg::SAMPLE_W-1:0] rem_next;
  logic [sets_pkg::COL_W-1:0]    sweep_column_next;

  // Trigger test and plot decision
  always_comb begin
    full = sweep_column >= inner_width;
    if (trigger_falling) begin
      crossed = (last_sample > sample) && (last_sample > trigger_level) &&
                (sample < trigger_level);
    end else begin
      crossed = (last_sample < sample) && (last_sample < trigger_level) &&
                (sample > trigger_level);
    end
    hit = full && crossed;

    phase_inc = phase + 1'b1;
    rem_plus  = {1'b0, rem} + 1'b1;
    if (phase_inc == '0 || rem_plus == {1'b0, divisor}) begin
      rem_inc = '0;
    end else begin
      rem_inc = rem_plus[sets_pkg::SAMPLE_W-1:0];
    end

    col_eff    = hit ? '0 : sweep_column;
    phase_next = hit ? '0 : phase_inc;
    rem_next   = hit ? '0 : rem_inc;
    still_full = col_eff >= inner_width;
    do_plot    = !still_full && (rem_next == '0);
    sweep_column_next = do_plot ? col_eff + 1'b1 : col_eff;
  end

  // Sweep state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= '0;
      rem          <= '0;
      sweep_column <= '0;
      last_sample  <= sets_pkg::SAMPLE_MIN;
    end else if (accept) begin
      phase        <= phase_next;
      rem          <= rem_next;
      sweep_column <= sweep_column_next;
      if (still_full || do_plot) begin
        last_sample <= sample;
      end
    end else if (rem_res.done) begin
      rem <= rem_res.value;
    end
  end

  // Plot stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      plot_valid <= 1'b0;
    end else if (advance) begin
      plot_valid <= accept && do_plot;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && accept) begin
      plot.column        <= col_eff;
      plot.sample        <= sample;
      plot.sample_before <= last_sample;
      plot.draw_span     <= col_eff != '0;
      plot.restarted     <= hit;
    end
  end

endmodule
